// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// shared widths and constants of the trip speed statistics unit
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int SPEED_W = 12;   // speed in 1/16 km/h
    localparam int DIST_W  = 48;   // distance accumulator
    localparam int MOVE_W  = 32;   // moving seconds counter
    localparam int FILL_W  = 10;   // reported fill count
    localparam int QCNT_W  = 4;    // divider step counter, one step per quotient bit

    localparam logic [SPEED_W-1:0] THRESH_RESET = 12'd32;   // 2.0 km/h

    typedef logic [SPEED_W-1:0] t_speed;

endpackage

// ===== rtl/tss_if.sv =====
// ----------------------------------------------------------------------------
// tss_in_if / tss_out_if
// valid/ready channels for speed samples and statistics results
// ----------------------------------------------------------------------------
interface tss_in_if;
    logic                  valid;
    logic                  ready;
    tss_pkg::t_speed       speed_sample;

    modport source (output valid, output speed_sample, input ready);
    modport sink   (input valid, input speed_sample, output ready);
endinterface

interface tss_out_if;
    logic                          valid;
    logic                          ready;
    tss_pkg::t_speed               window_average;
    tss_pkg::t_speed               recent_average;
    logic [tss_pkg::DIST_W-1:0]    distance_total;
    logic [tss_pkg::MOVE_W-1:0]    moving_time;
    logic [tss_pkg::FILL_W-1:0]    fill_count;
    logic                          was_moving;

    modport source (output valid, output window_average, output recent_average,
                    output distance_total, output moving_time, output fill_count,
                    output was_moving, input ready);
    modport sink   (input valid, input window_average, input recent_average,
                    input distance_total, input moving_time, input fill_count,
                    input was_moving, output ready);
endinterface

// ===== rtl/tss_ring.sv =====
// ----------------------------------------------------------------------------
// tss_ring
// sample ring memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tss_ring #(
    parameter int DEPTH = 600,
    parameter int AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  tss_pkg::t_speed             i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output tss_pkg::t_speed             o_rdata
);

    tss_pkg::t_speed r_mem [DEPTH];
    tss_pkg::t_speed r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tss_divider.sv =====
// ----------------------------------------------------------------------------
// tss_divider
// restoring divider, one quotient bit per cycle, quotient fits in a speed
// ----------------------------------------------------------------------------
module tss_divider #(
    parameter int DIVISOR_W = 10
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [DIVISOR_W+tss_pkg::SPEED_W-1:0]   i_dividend,
    input  logic [DIVISOR_W-1:0]                    i_divisor,
    output logic                                    o_done,
    output tss_pkg::t_speed                         o_quotient
);

    localparam int W = DIVISOR_W + tss_pkg::SPEED_W;

    logic                        r_busy;
    logic                        r_done;
    logic [tss_pkg::QCNT_W-1:0]  r_cnt;
    logic [W-1:0]                r_rem;
    logic [W-1:0]                r_dsh;
    tss_pkg::t_speed             r_q;
    logic                        fits;

    // dividend is below divisor << SPEED_W, so SPEED_W steps are enough
    assign fits = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tss_pkg::QCNT_W'(tss_pkg::SPEED_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsh <= W'(i_divisor) << (tss_pkg::SPEED_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[tss_pkg::SPEED_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== rtl/trip_speed_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// trip_speed_statistics_unit
// moving-window speed statistics, distance and moving time per speed sample
// ----------------------------------------------------------------------------
// Takes one speed item (1/16 km/h) at a time and returns one result item for
// it. A sample at or above the moving threshold is counted: moving time and
// distance go up (both saturate; km = distance / 57600), and the sample enters
// a WINDOW-deep ring memory with a running sum and a short list of the newest
// RECENT samples. The result carries the window average, the recent average
// (both floor, zero while the window is empty), distance, moving time, the
// low bits of the fill count and the moving flag. An item passes the ring
// read, the read-modify-write of the ring and sums (moving samples only), then
// two 12-step divides in one shared bit-serial divider (none while the window
// is empty). A new item is taken once the previous one has reached the output
// register, while that result may still wait there. The ring memory has no
// clearing pass; entries are read back only once written.
module trip_speed_statistics_unit #(
    parameter int WINDOW = 600,
    parameter int RECENT = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tss_pkg::SPEED_W-1:0]     i_cfg_wdata,
    tss_in_if.sink                          i_sample,
    tss_out_if.source                       o_result
);

    // widths derived from the window and recent depths
    localparam int AW     = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = CNT_W + tss_pkg::SPEED_W;
    localparam int RD     = (RECENT < WINDOW) ? RECENT : WINDOW;   // entries ever read
    localparam int RN_W   = $clog2(RD + 1);
    localparam int RSUM_W = RN_W + tss_pkg::SPEED_W;
    localparam int DVS_W  = (CNT_W > RN_W) ? CNT_W : RN_W;
    localparam int DVD_W  = DVS_W + tss_pkg::SPEED_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_DIVW   = 3'd2;
    localparam logic [2:0] ST_WAITW  = 3'd3;
    localparam logic [2:0] ST_WAITR  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                     r_state, n_state;
    tss_pkg::t_speed                r_thresh;
    tss_pkg::t_speed                r_speed;
    logic                           r_moving;

    logic [AW-1:0]                  r_wp, n_wp;
    logic [CNT_W-1:0]               r_held, n_held;
    logic [SUM_W-1:0]               r_sum, n_sum;
    logic [RSUM_W-1:0]              r_rsum, n_rsum;
    tss_pkg::t_speed                r_recent [RD];
    logic [tss_pkg::MOVE_W-1:0]     r_mtime, n_mtime;
    logic [tss_pkg::DIST_W-1:0]     r_dist, n_dist;
    tss_pkg::t_speed                r_wavg, n_wavg;
    tss_pkg::t_speed                r_ravg, n_ravg;

    // output register
    logic                           r_out_valid;
    tss_pkg::t_speed                r_out_wavg;
    tss_pkg::t_speed                r_out_ravg;
    logic [tss_pkg::DIST_W-1:0]     r_out_dist;
    logic [tss_pkg::MOVE_W-1:0]     r_out_mtime;
    logic [tss_pkg::FILL_W-1:0]     r_out_fill;
    logic                           r_out_moving;

    logic                           accept;
    logic                           update;
    logic                           load_out;
    logic                           full;
    tss_pkg::t_speed                ring_rdata;
    logic [tss_pkg::DIST_W:0]       dist_add;
    logic [CNT_W+tss_pkg::FILL_W-1:0] held_ext;
    logic [DVS_W-1:0]               recent_n;

    logic                           div_start;
    logic [DVD_W-1:0]               div_dividend;
    logic [DVS_W-1:0]               div_divisor;
    logic                           div_done;
    tss_pkg::t_speed                div_q;

    assign i_sample.ready = (r_state == ST_IDLE);
    assign accept         = i_sample.valid && i_sample.ready;
    assign update         = (r_state == ST_UPDATE);
    assign full           = (r_held == CNT_W'(WINDOW));
    assign load_out       = (r_state == ST_DONE) && (!r_out_valid || o_result.ready);

    // ring: read the slot about to be overwritten at accept, write a moving sample there next cycle
    tss_ring #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (update),
        .i_waddr (r_wp),
        .i_wdata (r_speed),
        .i_re    (accept),
        .i_raddr (r_wp),
        .o_rdata (ring_rdata)
    );

    // recent count is min(fill, depth of recent list)
    assign recent_n = (DVS_W'(r_held) < DVS_W'(RD)) ? DVS_W'(r_held) : DVS_W'(RD);

    assign div_start    = ((r_state == ST_DIVW) && (r_held != '0)) ||
                          ((r_state == ST_WAITW) && div_done);
    assign div_dividend = (r_state == ST_DIVW) ? DVD_W'(r_sum) : DVD_W'(r_rsum);
    assign div_divisor  = (r_state == ST_DIVW) ? DVS_W'(r_held) : recent_n;

    tss_divider #(
        .DIVISOR_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign dist_add = {1'b0, r_dist} + (tss_pkg::DIST_W + 1)'(r_speed);

    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        n_held  = r_held;
        n_sum   = r_sum;
        n_rsum  = r_rsum;
        n_mtime = r_mtime;
        n_dist  = r_dist;
        n_wavg  = r_wavg;
        n_ravg  = r_ravg;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_sample.speed_sample >= r_thresh) ? ST_UPDATE : ST_DIVW;
                end
            end
            ST_UPDATE: begin
                // oldest sample leaves the sum once the window is full
                n_sum  = r_sum + SUM_W'(r_speed)
                         - (full ? SUM_W'(ring_rdata) : SUM_W'(0));
                n_rsum = r_rsum + RSUM_W'(r_speed) - RSUM_W'(r_recent[RD-1]);
                n_wp   = (r_wp == AW'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
                n_held = full ? r_held : r_held + 1'b1;
                if (r_mtime != '1) begin
                    n_mtime = r_mtime + 1'b1;
                end
                n_dist = dist_add[tss_pkg::DIST_W] ? '1 : dist_add[tss_pkg::DIST_W-1:0];
                n_state = ST_DIVW;
            end
            ST_DIVW: begin
                if (r_held == '0) begin
                    // empty window reports zero averages
                    n_wavg  = '0;
                    n_ravg  = '0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_WAITW;
                end
            end
            ST_WAITW: begin
                if (div_done) begin
                    n_wavg  = div_q;
                    n_state = ST_WAITR;
                end
            end
            ST_WAITR: begin
                if (div_done) begin
                    n_ravg  = div_q;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_thresh <= tss_pkg::THRESH_RESET;
            r_wp     <= '0;
            r_held   <= '0;
            r_sum    <= '0;
            r_rsum   <= '0;
            r_mtime  <= '0;
            r_dist   <= '0;
            for (int i = 0; i < RD; i++) begin
                r_recent[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_held  <= n_held;
            r_sum   <= n_sum;
            r_rsum  <= n_rsum;
            r_mtime <= n_mtime;
            r_dist  <= n_dist;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            // newest moving sample enters at the head of the recent list
            if (update) begin
                r_recent[0] <= r_speed;
                for (int i = 1; i < RD; i++) begin
                    r_recent[i] <= r_recent[i-1];
                end
            end
        end
    end

    // item payload and division results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_speed  <= i_sample.speed_sample;
            r_moving <= (i_sample.speed_sample >= r_thresh);
        end
        r_wavg <= n_wavg;
        r_ravg <= n_ravg;
    end

    assign held_ext = {{tss_pkg::FILL_W{1'b0}}, r_held};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_wavg   <= r_wavg;
            r_out_ravg   <= r_ravg;
            r_out_dist   <= r_dist;
            r_out_mtime  <= r_mtime;
            r_out_fill   <= held_ext[tss_pkg::FILL_W-1:0];
            r_out_moving <= r_moving;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.window_average = r_out_wavg;
    assign o_result.recent_average = r_out_ravg;
    assign o_result.distance_total = r_out_dist;
    assign o_result.moving_time    = r_out_mtime;
    assign o_result.fill_count     = r_out_fill;
    assign o_result.was_moving     = r_out_moving;

endmodule

// ===== verif/trip_stats_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trip_stats_checker
// watches the sample and result channels, predicts the trip statistics for
// every accepted sample and compares each result item field by field
// ----------------------------------------------------------------------------
module trip_stats_checker #(
    parameter int WINDOW = 600,
    parameter int RECENT = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tss_pkg::SPEED_W-1:0] i_cfg_wdata,
    tss_in_if                           sample_bus,
    tss_out_if                          result_bus,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results_checked,
    output int                          o_full_window_results
);
    import tss_pkg::*;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;
    localparam logic [MOVE_W-1:0] MOVE_SAT = '1;

    typedef struct packed {
        t_speed              window_average;
        t_speed              recent_average;
        logic [DIST_W-1:0]   distance_total;
        logic [MOVE_W-1:0]   moving_time;
        logic [FILL_W-1:0]   fill_count;
        logic                was_moving;
    } t_trip_stats;

    // private copy of the block state
    t_speed              ring_speed [WINDOW];
    int unsigned         ring_wr;
    int unsigned         ring_held;
    logic [63:0]         ring_sum;
    t_speed              newest_speed [RECENT];
    logic [MOVE_W-1:0]   moving_secs;
    logic [DIST_W-1:0]   distance_acc;
    t_speed              move_threshold;

    t_trip_stats         stats_due [$];

    function automatic void clear_trip();
        ring_wr        = 0;
        ring_held      = 0;
        ring_sum       = '0;
        moving_secs    = '0;
        distance_acc   = '0;
        move_threshold = THRESH_RESET;
        for (int i = 0; i < RECENT; i++) newest_speed[i] = '0;
    endfunction

    // update the trip state with one sample and return its statistics
    function automatic t_trip_stats advance_trip(input t_speed spd);
        t_trip_stats st;
        logic [63:0] recent_sum;
        int unsigned n;
        st = '0;
        recent_sum = '0;
        st.was_moving = (spd >= move_threshold);
        if (st.was_moving) begin
            if (moving_secs != MOVE_SAT) moving_secs++;
            if (DIST_SAT - distance_acc < {{(DIST_W-SPEED_W){1'b0}}, spd})
                distance_acc = DIST_SAT;
            else
                distance_acc += spd;
            // full window: oldest sample drops out of the sum
            if (ring_held >= WINDOW) ring_sum -= ring_speed[ring_wr];
            ring_speed[ring_wr] = spd;
            ring_sum += spd;
            ring_wr = (ring_wr + 1 >= WINDOW) ? 0 : ring_wr + 1;
            if (ring_held < WINDOW) ring_held++;
            for (int i = RECENT - 1; i > 0; i--) newest_speed[i] = newest_speed[i-1];
            newest_speed[0] = spd;
        end
        // empty window leaves both averages at zero
        if (ring_held != 0) begin
            st.window_average = t_speed'(ring_sum / ring_held);
            n = (ring_held < RECENT) ? ring_held : RECENT;
            for (int i = 0; i < n; i++) recent_sum += newest_speed[i];
            st.recent_average = t_speed'(recent_sum / n);
        end
        st.distance_total = distance_acc;
        st.moving_time    = moving_secs;
        st.fill_count     = FILL_W'(ring_held);
        if (ring_held == WINDOW) o_full_window_results++;
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", o_results_checked, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_result();
        t_trip_stats want;
        if (stats_due.size() == 0) begin
            report_mismatch("result item with no sample waiting");
        end else begin
            want = stats_due.pop_front();
            check_field("window_average", result_bus.window_average, want.window_average);
            check_field("recent_average", result_bus.recent_average, want.recent_average);
            check_field("distance_total", result_bus.distance_total, want.distance_total);
            check_field("moving_time", result_bus.moving_time, want.moving_time);
            check_field("fill_count", result_bus.fill_count, want.fill_count);
            check_field("was_moving", result_bus.was_moving, want.was_moving);
        end
        o_results_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_trip();
            stats_due.delete();
            o_fail_count          = 0;
            o_results_checked     = 0;
            o_full_window_results = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) check_result();
            if (i_cfg_we) move_threshold = i_cfg_wdata;
            if (sample_bus.valid && sample_bus.ready)
                stats_due.push_back(advance_trip(sample_bus.speed_sample));
        end
        o_pending = stats_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// regression of the trip speed statistics unit: directed edge samples, then
// random phases under several moving thresholds, most with random stalls on both
// channels; results are predicted and checked by trip_stats_checker
// ----------------------------------------------------------------------------
module testbench;
    import tss_pkg::*;

    localparam int WINDOW       = 600;
    localparam int RECENT       = 5;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE       = 40;      // a little above the per-item latency of the block
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    // the limit leaves a wide margin over the slowest correct run of roughly
    // 1700 items plus stalls and pauses
    localparam int CYCLE_LIMIT  = 1000000;

    logic   i_clk;
    logic   i_rst_n;
    logic   cfg_we;
    t_speed cfg_wdata;

    tss_in_if  sample_bus ();
    tss_out_if result_bus ();

    int fail_count;
    int pending;
    int results_checked;
    int full_window_results;

    // stimulus control
    bit tx_gaps_on;
    bit rx_gaps_on;
    bit hold_req;
    int hold_left;
    int samples_sent;
    int threshold_writes;
    int cycle_count;

    trip_speed_statistics_unit #(
        .WINDOW (WINDOW),
        .RECENT (RECENT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_sample    (sample_bus),
        .o_result    (result_bus)
    );

    trip_stats_checker #(
        .WINDOW (WINDOW),
        .RECENT (RECENT)
    ) u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_wdata           (cfg_wdata),
        .sample_bus            (sample_bus),
        .result_bus            (result_bus),
        .o_fail_count          (fail_count),
        .o_pending             (pending),
        .o_results_checked     (results_checked),
        .o_full_window_results (full_window_results)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit, counted in clock cycles
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random ready, long hold-off counted here when asked for
    initial begin
        result_bus.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end else if (rx_gaps_on) begin
                result_bus.ready <= ($urandom_range(99) >= 32);
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // offer one sample item, with a random gap first, and wait for its acceptance
    task automatic send_sample(input t_speed spd);
        int gap;
        gap = 0;
        if (tx_gaps_on)
            while ($urandom_range(99) < 32) gap++;
        @(negedge i_clk);
        if (gap != 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_bus.valid        <= 1'b1;
        sample_bus.speed_sample <= spd;
        @(posedge i_clk);
        while (!sample_bus.ready) @(posedge i_clk);
        samples_sent++;
    endtask

    // stop offering, let every due result arrive, then let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        sample_bus.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // threshold writes happen only with the block idle
    task automatic set_threshold(input t_speed thr);
        drain_results();
        cfg_wdata <= thr;
        cfg_we    <= 1'b1;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        threshold_writes++;
    endtask

    // mostly moving samples so the window fills and wraps, plus edges and noise
    function automatic t_speed pick_speed(input t_speed thr);
        int unsigned roll;
        roll = $urandom_range(9);
        case (roll)
            0, 1, 2, 3, 4, 5: begin
                return t_speed'($urandom_range(4095, thr));
            end
            6: begin
                return t_speed'($urandom);
            end
            7: begin
                // right at the threshold or just below it
                if (thr != 0 && $urandom_range(1)) return thr - 1'b1;
                return thr;
            end
            8: begin
                return $urandom_range(1) ? t_speed'('1) : t_speed'('0);
            end
            default: begin
                if (thr == 0) return t_speed'($urandom);
                return t_speed'($urandom_range(thr - 1, 0));
            end
        endcase
    endfunction

    task automatic run_phase(input t_speed thr, input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            // sender pause until every due result is back
            if (i == pause_at) drain_results();
            send_sample(pick_speed(thr));
        end
    endtask

    initial begin
        sample_bus.valid        = 1'b0;
        sample_bus.speed_sample = '0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        i_rst_n                 = 1'b0;
        tx_gaps_on              = 1'b1;
        rx_gaps_on              = 1'b1;
        hold_req                = 1'b0;
        samples_sent            = 0;
        threshold_writes        = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part under the reset threshold: empty window first
        send_sample(12'd0);
        send_sample(12'd31);
        send_sample(THRESH_RESET);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd1);
        send_sample(12'd33);
        send_sample(12'd2048);
        send_sample(12'd4094);

        // zero threshold: every sample counts, zero speed too
        set_threshold(12'd0);
        send_sample(12'd0);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1365);

        // top threshold: only full-scale speed counts
        set_threshold(12'd4095);
        send_sample(12'd4094);
        send_sample(12'd4095);
        send_sample(12'd0);

        set_threshold(12'd1);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd2730);

        // random phases, over which the window fills and wraps
        set_threshold(t_speed'($urandom_range(200, 1)));
        run_phase(u_checker.move_threshold, 400, -1);

        // long stretch without idling on either side
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_threshold(12'd0);
        run_phase(12'd0, 300, -1);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;

        set_threshold(12'd4095);
        run_phase(12'd4095, 40, -1);

        // receiver holds off while samples keep coming, so the block backs up
        set_threshold(t_speed'($urandom));
        hold_req = 1'b1;
        run_phase(cfg_wdata, 150, -1);

        set_threshold(THRESH_RESET);
        run_phase(THRESH_RESET, 300, 150);

        set_threshold(t_speed'($urandom_range(600, 1)));
        run_phase(cfg_wdata, 460, -1);

        // end of stimulus: wait for the last results, then a quiet tail
        @(negedge i_clk);
        sample_bus.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d samples over %0d threshold settings, %0d results checked",
                 samples_sent, threshold_writes + 1, results_checked);
        $display("%0d results came with the window full, one hold-off of %0d cycles",
                 full_window_results, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results still due", fail_count, pending);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_ring.sv
rtl/tss_divider.sv
rtl/trip_speed_statistics_unit.sv
verif/trip_stats_checker.sv
verif/testbench.sv
